// ===== hw/rtl/flr_pkg.sv =====
// Shared constants for the fixed-point line rasterizer.
`default_nettype none

package flr_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int IN_X_W  = 8;
    localparam int IN_Y_W  = 7;
    localparam int PIX_X_W = 7;
    localparam int PIX_Y_W = 6;
    localparam int SPAN_W  = 7;
    localparam int K_W     = 8;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

endpackage

`default_nettype wire

// ===== hw/rtl/flr_div.sv =====
// Serial restoring divider that forms the unsigned gradient magnitude one bit per cycle.
`default_nettype none

module flr_div #(
    parameter int FRACTION_BITS = flr_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [flr_pkg::SPAN_W-1:0] numer,
    input  wire logic [flr_pkg::SPAN_W-1:0] denom,
    output logic                           done,
    output logic [FRACTION_BITS:0]         quotient
);
    import flr_pkg::*;

    localparam int STEPS = SPAN_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [STEPS-1:0]  dvd_reg;
    logic [STEPS-1:0]  quo_reg;
    logic [SPAN_W-1:0] rem_reg;
    logic [SPAN_W-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;

    logic [SPAN_W:0]   trial;
    logic [SPAN_W:0]   diff;
    logic              fits;

    assign trial = {rem_reg, dvd_reg[STEPS-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(STEPS);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {numer, {FRACTION_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= denom;
            quo_reg <= '0;
        end else if (run_reg) begin
            dvd_reg <= {dvd_reg[STEPS-2:0], 1'b0};
            rem_reg <= fits ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
            quo_reg <= {quo_reg[STEPS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[FRACTION_BITS:0];

endmodule

`default_nettype wire

// ===== hw/rtl/fixed_point_line_rasterizer.sv =====
// Top level of the fixed-point line rasterizer: endpoint check, sequencer and pixel walk.
// The slave channel takes one line per transaction: two endpoints in s_tdata.
// The master channel gives the pixels of that line, up to two per transaction, in walk
// order; m_tlast marks the final transaction of a line and m_tuser is the status
// flag (1 for rejected endpoints, in which case one transaction carries no pixels).
// After a line is accepted, the serial divider forms the gradient, one quotient
// bit per cycle.
// Then one beat leaves per cycle while the receiver keeps m_tready high; a line of span
// S gives ceil(S/2) beats.
// A rejected line is answered with one status beat via ST_REJECT and the output register.
// s_tready is high only while the sequencer is idle; the last beat of the previous
// line may still wait in the output register at that time.
// When the receiver stalls, the walk halts with the beat held in the output register.
// Reset empties the output register and returns the sequencer to idle.
`default_nettype none

module fixed_point_line_rasterizer #(
    parameter int SCREEN_WIDTH  = flr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = flr_pkg::SCREEN_HEIGHT_DEF,
    parameter int FRACTION_BITS = flr_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // start_x[7:0], start_y[14:8], end_x[22:15], end_y[29:23], zero fill.
    input  wire logic [flr_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // pixel_a_x[6:0], pixel_a_y[12:7], pixel_b_x[19:13], pixel_b_y[25:20],
    // pixel_b_valid[26], zero fill.
    output logic [flr_pkg::M_TDATA_W-1:0]     m_tdata,
    // status[0].
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import flr_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_WALK   = 3'd2;
    localparam logic [2:0] ST_REJECT = 3'd3;

    localparam logic [IN_X_W-1:0] X_MAX = IN_X_W'(SCREEN_WIDTH - 1);
    localparam logic [IN_Y_W-1:0] Y_MAX = IN_Y_W'(SCREEN_HEIGHT - 1);
    localparam int GW = FRACTION_BITS + 2;
    localparam int AW = FRACTION_BITS + 9;

    logic [2:0]         state_reg;
    logic [SPAN_W-1:0]  major_start_reg;
    logic [SPAN_W-1:0]  minor_start_reg;
    logic [SPAN_W-1:0]  span_reg;
    logic               xmajor_reg;
    logic               neg_reg;
    logic [GW-1:0]      grad_reg;
    logic [AW-1:0]      acc_reg;
    logic [K_W-1:0]     k_reg;

    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic               m_tuser_reg;
    logic               m_tlast_reg;

    logic [IN_X_W-1:0]  ax, bx, dx;
    logic [IN_Y_W-1:0]  ay, by, dy;
    logic               bad, xmajor, swap, accept;
    logic [IN_X_W-1:0]  x1;
    logic [IN_Y_W-1:0]  y1;
    logic               div_done;
    logic [FRACTION_BITS:0] quotient;
    logic [GW-1:0]      grad_mag;

    logic               out_free;
    logic               load_beat;
    logic [AW-1:0]      grad_ext;
    logic [AW-1:0]      acc_b;
    logic [SPAN_W-1:0]  minor_a, minor_b, major_a, major_b;
    logic [PIX_X_W-1:0] ax_pix, bx_pix;
    logic [PIX_Y_W-1:0] ay_pix, by_pix;
    logic               b_present, beat_last;
    logic [K_W-1:0]     k_plus1, k_plus2;

    assign ax = s_tdata[7:0];
    assign ay = s_tdata[14:8];
    assign bx = s_tdata[22:15];
    assign by = s_tdata[29:23];

    assign accept = s_tvalid && s_tready;
    assign bad = (ax == bx && ay == by) || ax > X_MAX || bx > X_MAX
                 || ay > Y_MAX || by > Y_MAX;
    assign dx = (ax > bx) ? ax - bx : bx - ax;
    assign dy = (ay > by) ? ay - by : by - ay;
    assign xmajor = {1'b0, dy} < dx;
    assign swap = xmajor ? !(ax < bx) : !(ay < by);
    assign x1 = swap ? bx : ax;
    assign y1 = swap ? by : ay;

    flr_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && !bad),
        .numer   (xmajor ? dy : dx[SPAN_W-1:0]),
        .denom   (xmajor ? dx[SPAN_W-1:0] : dy),
        .done    (div_done),
        .quotient(quotient)
    );

    assign grad_mag = {1'b0, quotient};

    assign out_free  = !m_tvalid_reg || m_tready;
    assign load_beat = (state_reg == ST_WALK || state_reg == ST_REJECT) && out_free;
    assign grad_ext = {{(AW - GW){grad_reg[GW-1]}}, grad_reg};
    assign acc_b    = acc_reg + grad_ext;
    assign minor_a  = minor_start_reg + acc_reg[FRACTION_BITS +: SPAN_W];
    assign minor_b  = minor_start_reg + acc_b[FRACTION_BITS +: SPAN_W];
    assign major_a  = major_start_reg + k_reg[SPAN_W-1:0];
    assign major_b  = major_a + 1'b1;
    assign k_plus1  = k_reg + 1'b1;
    assign k_plus2  = k_reg + 2'd2;
    assign b_present = k_plus1 < {1'b0, span_reg};
    assign beat_last = k_plus2 >= {1'b0, span_reg};

    assign ax_pix = xmajor_reg ? major_a : minor_a;
    assign ay_pix = xmajor_reg ? minor_a[PIX_Y_W-1:0] : major_a[PIX_Y_W-1:0];
    assign bx_pix = b_present ? (xmajor_reg ? major_b : minor_b) : '0;
    assign by_pix = b_present ? (xmajor_reg ? minor_b[PIX_Y_W-1:0]
                                            : major_b[PIX_Y_W-1:0]) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= load_beat || (m_tvalid_reg && !m_tready);
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= bad ? ST_REJECT : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (out_free && beat_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_REJECT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            xmajor_reg      <= xmajor;
            major_start_reg <= xmajor ? x1[SPAN_W-1:0] : y1;
            minor_start_reg <= xmajor ? y1 : x1[SPAN_W-1:0];
            span_reg        <= xmajor ? dx[SPAN_W-1:0] : dy;
            neg_reg         <= xmajor ? ((swap ? ay : by) < y1)
                                      : ((swap ? ax : bx) < x1);
        end
        if (state_reg == ST_DIV && div_done) begin
            grad_reg <= neg_reg ? -grad_mag : grad_mag;
            acc_reg  <= '0;
            k_reg    <= '0;
        end
        if (state_reg == ST_WALK && out_free) begin
            acc_reg     <= acc_reg + {grad_ext[AW-2:0], 1'b0};
            k_reg       <= k_plus2;
            m_tdata_reg <= {{(M_TDATA_W - 27){1'b0}}, b_present, by_pix, bx_pix,
                            ay_pix, ax_pix};
            m_tuser_reg <= 1'b0;
            m_tlast_reg <= beat_last;
        end
        if (state_reg == ST_REJECT && out_free) begin
            m_tdata_reg <= '0;
            m_tuser_reg <= 1'b1;
            m_tlast_reg <= 1'b1;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ===== tb/fixed_point_line_rasterizer_test.sv =====
// Self-checking testbench for the line rasterizer: predicts every output beat of each line.
`timescale 1ns / 100ps

module fixed_point_line_rasterizer_test;

    localparam int SCREEN_W       = flr_pkg::SCREEN_WIDTH_DEF;
    localparam int SCREEN_H       = flr_pkg::SCREEN_HEIGHT_DEF;
    localparam int FRAC_BITS      = flr_pkg::FRACTION_BITS_DEF;
    localparam int IN_XW          = flr_pkg::IN_X_W;
    localparam int IN_YW          = flr_pkg::IN_Y_W;
    localparam int PIX_XW         = flr_pkg::PIX_X_W;
    localparam int PIX_YW         = flr_pkg::PIX_Y_W;
    localparam int RANDOM_LINES   = 200;
    localparam int PHASE_COUNT    = 3;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam bit STATUS_OK            = 1'b0;
    localparam bit STATUS_BAD_ENDPOINTS = 1'b1;

    typedef struct {
        bit [flr_pkg::IN_X_W-1:0] start_x;
        bit [flr_pkg::IN_Y_W-1:0] start_y;
        bit [flr_pkg::IN_X_W-1:0] end_x;
        bit [flr_pkg::IN_Y_W-1:0] end_y;
    } line_t;

    typedef struct {
        logic [flr_pkg::PIX_X_W-1:0] a_x;
        logic [flr_pkg::PIX_Y_W-1:0] a_y;
        logic [flr_pkg::PIX_X_W-1:0] b_x;
        logic [flr_pkg::PIX_Y_W-1:0] b_y;
        logic                        b_valid;
        logic                        status;
        logic                        last;
    } pixel_beat_t;

    class line_pixel_scoreboard;
        pixel_beat_t expected_beats[$];
        int unsigned failures;

        function new();
            failures = 0;
        endfunction

        function int unsigned beats_pending();
            return expected_beats.size();
        endfunction

        // Queues a status beat for a bad line, or walks the major axis for pixel beats.
        function void note_line(line_t l);
            int ax, ay, bx, by, dx, dy;
            int near_x, near_y, far_x, far_y, span, minor_diff, offset;
            longint quotient, slope;
            bit x_major;
            pixel_beat_t beat;
            ax = l.start_x;
            ay = l.start_y;
            bx = l.end_x;
            by = l.end_y;
            beat = '{default: '0};
            if ((ax == bx && ay == by) || ax >= SCREEN_W || bx >= SCREEN_W ||
                ay >= SCREEN_H || by >= SCREEN_H) begin
                beat.status = STATUS_BAD_ENDPOINTS;
                beat.last = 1'b1;
                expected_beats.push_back(beat);
                return;
            end
            dx = (ax > bx) ? ax - bx : bx - ax;
            dy = (ay > by) ? ay - by : by - ay;
            x_major = dy < dx;
            if (x_major ? (ax < bx) : (ay < by)) begin
                near_x = ax; near_y = ay; far_x = bx; far_y = by;
            end else begin
                near_x = bx; near_y = by; far_x = ax; far_y = ay;
            end
            span = x_major ? far_x - near_x : far_y - near_y;
            minor_diff = x_major ? far_y - near_y : far_x - near_x;
            quotient = (longint'(minor_diff < 0 ? -minor_diff : minor_diff) <<< FRAC_BITS)
                       / span;
            slope = (minor_diff < 0) ? -quotient : quotient;
            for (int k = 0; k < span; k++) begin
                offset = int'((slope * k) >>> FRAC_BITS);
                if (k % 2 == 0) begin
                    beat = '{default: '0};
                    beat.status = STATUS_OK;
                    beat.a_x = PIX_XW'(x_major ? near_x + k : near_x + offset);
                    beat.a_y = PIX_YW'(x_major ? near_y + offset : near_y + k);
                end else begin
                    beat.b_x = PIX_XW'(x_major ? near_x + k : near_x + offset);
                    beat.b_y = PIX_YW'(x_major ? near_y + offset : near_y + k);
                    beat.b_valid = 1'b1;
                end
                beat.last = (k == span - 1);
                if (k % 2 == 1 || k == span - 1)
                    expected_beats.push_back(beat);
            end
        endfunction

        function void check_field(string field_name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field_name, want, got);
                failures++;
            end
        endfunction

        function void check_beat(logic [flr_pkg::M_TDATA_W-1:0] tdata, logic tuser,
                                 logic tlast);
            pixel_beat_t want;
            if (expected_beats.size() == 0) begin
                $error("unexpected transaction: tdata %h, tuser %b, tlast %b",
                       tdata, tuser, tlast);
                failures++;
                return;
            end
            want = expected_beats.pop_front();
            check_field("pixel_a_x", want.a_x, tdata[6:0]);
            check_field("pixel_a_y", want.a_y, tdata[12:7]);
            check_field("pixel_b_x", want.b_x, tdata[19:13]);
            check_field("pixel_b_y", want.b_y, tdata[25:20]);
            check_field("pixel_b_valid", want.b_valid, tdata[26]);
            check_field("status", want.status, tuser);
            check_field("last", want.last, tlast);
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [flr_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [flr_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;

    line_pixel_scoreboard pixel_board = new();
    int tx_idle_pct = 8;
    int rx_idle_pct = 64;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    fixed_point_line_rasterizer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            pixel_board.check_beat(m_tdata, m_tuser, m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_line(input line_t l);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, l.end_y, l.end_x, l.start_y, l.start_x};
        do
            @(posedge aclk);
        while (!s_tready);
        pixel_board.note_line(l);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (pixel_board.beats_pending() != 0)
            @(posedge aclk);
    endtask

    function automatic line_t random_line();
        line_t l;
        int kind, sx, sy;
        kind = $urandom_range(0, 99);
        sx = $urandom_range(0, SCREEN_W - 1);
        sy = $urandom_range(0, SCREEN_H - 1);
        l.start_x = IN_XW'(sx);
        l.start_y = IN_YW'(sy);
        if (kind < 45) begin
            l.end_x = IN_XW'($urandom_range(sx > 10 ? sx - 10 : 0,
                                            sx < SCREEN_W - 11 ? sx + 10 : SCREEN_W - 1));
            l.end_y = IN_YW'($urandom_range(sy > 10 ? sy - 10 : 0,
                                            sy < SCREEN_H - 11 ? sy + 10 : SCREEN_H - 1));
        end else if (kind < 80) begin
            l.end_x = IN_XW'($urandom_range(0, SCREEN_W - 1));
            l.end_y = IN_YW'($urandom_range(0, SCREEN_H - 1));
        end else if (kind < 88) begin
            l.end_x = IN_XW'(sx);
            l.end_y = IN_YW'(sy);
        end else begin
            l.start_x = IN_XW'($urandom_range(0, 255));
            l.start_y = IN_YW'($urandom_range(0, 127));
            l.end_x = IN_XW'($urandom_range(0, 255));
            l.end_y = IN_YW'($urandom_range(0, 127));
        end
        return l;
    endfunction

    initial begin
        line_t directed_lines[$];
        directed_lines.push_back('{0, 0, 127, 0});
        directed_lines.push_back('{127, 63, 0, 0});
        directed_lines.push_back('{0, 63, 127, 0});
        directed_lines.push_back('{127, 0, 0, 1});
        directed_lines.push_back('{10, 0, 10, 63});
        directed_lines.push_back('{40, 0, 0, 63});
        directed_lines.push_back('{0, 0, 20, 20});
        directed_lines.push_back('{20, 20, 0, 0});
        directed_lines.push_back('{3, 3, 4, 3});
        directed_lines.push_back('{4, 3, 3, 3});
        directed_lines.push_back('{3, 3, 5, 4});
        directed_lines.push_back('{60, 30, 61, 33});
        directed_lines.push_back('{5, 5, 5, 5});
        directed_lines.push_back('{0, 0, 0, 0});
        directed_lines.push_back('{128, 0, 0, 0});
        directed_lines.push_back('{0, 0, 255, 63});
        directed_lines.push_back('{0, 64, 0, 0});
        directed_lines.push_back('{0, 0, 0, 127});
        directed_lines.push_back('{255, 127, 255, 127});
        directed_lines.push_back('{127, 63, 127, 0});
        directed_lines.push_back('{0, 1, 127, 62});
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_lines[i])
            send_line(directed_lines[i]);
        wait_for_drain();
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            tx_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 64 : 0;
            rx_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 8 : 0;
            for (int i = 0; i < RANDOM_LINES / PHASE_COUNT; i++) begin
                if (phase == PHASE_COUNT - 1 && i == 20)
                    hold_requests++;
                send_line(random_line());
            end
            wait_for_drain();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pixel_board.failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
